// ===== hdl/rank_radix_sorter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rank radix sorter
// Shared property forms used by the sorter's modules.
// ----------------------------------------------------------------------------
`ifndef RANK_RADIX_SORTER_ASSERT_SVH
`define RANK_RADIX_SORTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RRS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define RRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank radix sorter package
// Widths, capacity, shared types and the control state encoding.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int VALUE_W   = 32;
	localparam int RANK_W    = 6;
	localparam int MAX_ITEMS = 64;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W     = $clog2(MAX_ITEMS);

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [RANK_W-1:0]         rank_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [IDX_W-1:0]          idx_t;

	// Control state of the sorter.
	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;  // insert the broadcast value in order
		logic shl;  // shift the whole chain one cell toward the head
	} ctrl_t;

endpackage

// ===== hdl/rrs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank radix sorter channels
// Valid/ready interfaces for the input values and the sorted results.
// ----------------------------------------------------------------------------
interface rrs_in_if import rrs_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t value;
	logic   last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface rrs_out_if import rrs_pkg::*; ();
	logic   valid;
	logic   ready;
	value_t sorted_value;
	rank_t  rank;
	logic   already_sorted;
	logic   end_of_run;

	modport source (output valid, output sorted_value, output rank,
		output already_sorted, output end_of_run, input ready);
	modport sink   (input valid, input sorted_value, input rank,
		input already_sorted, input end_of_run, output ready);
endinterface

// ===== hdl/rrs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank radix sorter cell
// One slot of the ordered chain: holds a value, inserts or shifts in place.
// ----------------------------------------------------------------------------
module rrs_cell import rrs_pkg::*; (
	input  logic   clk,
	input  ctrl_t  ctrl,
	input  value_t new_val,
	input  logic   occ,
	input  value_t left_val,
	input  logic   left_gt,
	input  value_t right_val,
	output value_t val,
	output logic   gt
);

	value_t val_q;

	// An empty slot or a strictly larger value makes room for the new one,
	// so equal values keep their arrival order.
	assign gt  = !occ || (val_q > new_val);
	assign val = val_q;

	// Slot update: take the left neighbor, the new value, or the right one.
	always_ff @(posedge clk) begin
		if (ctrl.ins && gt) begin
			val_q <= left_gt ? left_val : new_val;
		end else if (ctrl.shl) begin
			val_q <= right_val;
		end
	end

endmodule

// ===== hdl/rrs_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank radix sorter chain
// A row of cells that keeps the stored values in stable ascending order.
// ----------------------------------------------------------------------------
module rrs_chain import rrs_pkg::*; (
	input  logic   clk,
	input  ctrl_t  ctrl,
	input  value_t new_val,
	input  cnt_t   cnt,
	output value_t head
);

	value_t vals [MAX_ITEMS];
	logic   gts  [MAX_ITEMS];

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		value_t left_val;
		logic   left_gt;
		value_t right_val;
		logic   occ;

		// Occupancy follows from the fill count: cells below it hold data.
		assign occ = cnt > cnt_t'(i);

		if (i == 0) begin : g_first
			assign left_val = '0;
			assign left_gt  = 1'b0;
		end else begin : g_mid
			assign left_val = vals[i-1];
			assign left_gt  = gts[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_val = '0;
		end else begin : g_body
			assign right_val = vals[i+1];
		end

		rrs_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_val   (new_val),
			.occ       (occ),
			.left_val  (left_val),
			.left_gt   (left_gt),
			.right_val (right_val),
			.val       (vals[i]),
			.gt        (gts[i])
		);
	end

	assign head = vals[0];

endmodule

// ===== hdl/rank_radix_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank radix sorter
// Collects a set of signed values in an ordered cell chain and emits them
// in ascending order, equal values in arrival order, each with its rank.
// ----------------------------------------------------------------------------
//  Channel | Direction | Request payload
//  din     | in        | value, last
//  dout    | out       | sorted_value, rank, already_sorted, end_of_run
//
// Loading takes one request per cycle; each value is placed into the chain
// by a broadcast compare in the cycle it is accepted.
// After a last request the chain shifts toward its head one cell per cycle
// while dout is ready, emitting one value with each shift.
// din is not ready during emission. A stall on dout holds the chain.
// Reset empties the chain; no clearing pass is needed.
// Requests beyond the chain capacity are dropped.
// ----------------------------------------------------------------------------
module rank_radix_sorter import rrs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	rrs_in_if.sink    din,
	rrs_out_if.source dout
);

	`include "rank_radix_sorter_assert.svh"

	state_t state_q, state_d;
	ctrl_t  ctrl;
	cnt_t   cnt_q;
	idx_t   idx_q;
	logic   flag_q;
	value_t prev_q;
	value_t head;
	logic   in_acc;
	logic   full;
	logic   out_free;

	logic   out_vld_q;
	value_t out_val_q;
	rank_t  out_rank_q;
	logic   out_srt_q;
	logic   out_eor_q;
	rank_t  rank_d;

	assign full     = cnt_q == cnt_t'(MAX_ITEMS);
	assign in_acc   = din.valid && din.ready;
	assign out_free = !out_vld_q || dout.ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and chain commands.
	always_comb begin
		state_d   = state_q;
		ctrl.ins  = 1'b0;
		ctrl.shl  = 1'b0;
		din.ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				din.ready = 1'b1;
				ctrl.ins  = din.valid && !full;
				if (din.valid && din.last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				ctrl.shl = out_free;
				if (out_free && cnt_q == cnt_t'(1)) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Ordered value chain.
	rrs_chain u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.new_val (din.value),
		.cnt     (cnt_q),
		.head    (head)
	);

	// Fill count, emit index and in-order tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			flag_q <= 1'b1;
		end else begin
			if (ctrl.ins) begin
				cnt_q <= cnt_q + cnt_t'(1);
				if (cnt_q != '0 && din.value < prev_q) begin
					flag_q <= 1'b0;
				end
			end else if (ctrl.shl) begin
				cnt_q <= cnt_q - cnt_t'(1);
				if (cnt_q == cnt_t'(1)) begin
					idx_q  <= '0;
					flag_q <= 1'b1;
				end else begin
					idx_q <= idx_q + idx_t'(1);
				end
			end
		end
	end

	// Last stored value, for the in-order check.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			prev_q <= din.value;
		end
	end

	// A new distinct value ranks at its sorted position; a tie repeats the rank.
	assign rank_d = (idx_q == '0 || head != out_val_q) ? rank_t'(idx_q) : out_rank_q;

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.shl) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			out_val_q  <= head;
			out_rank_q <= rank_d;
			out_srt_q  <= flag_q;
			out_eor_q  <= cnt_q == cnt_t'(1);
		end
	end

	assign dout.valid          = out_vld_q;
	assign dout.sorted_value   = out_val_q;
	assign dout.rank           = out_rank_q;
	assign dout.already_sorted = out_srt_q;
	assign dout.end_of_run     = out_eor_q;

	// Checks on the fill count and the load/emit sequencing.
	`RRS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= cnt_t'(MAX_ITEMS), "fill count above capacity")
	`RRS_ASSERT_NEXT(a_last_emit, in_acc && din.last, state_q == ST_EMIT && cnt_q != '0, "last request did not start a non-empty emission")
	`RRS_ASSERT_NEXT(a_shift_dec, ctrl.shl, cnt_q == $past(cnt_q) - cnt_t'(1), "shift did not consume one entry")
	`RRS_ASSERT_NEXT(a_eor_load, ctrl.shl && cnt_q == cnt_t'(1), state_q == ST_LOAD && out_eor_q && out_vld_q, "end of run not flagged on final shift")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank radix sorter regression
// Streams sets of signed values into the sorter and checks every sorted
// result against a software ranking of the same set. Directed sets cover the
// value extremes, ties and ordered input. Random sets follow, including one
// set that fills the store and then overruns it. Both channels stall at
// random, and there is one long stall on the result side.
// ----------------------------------------------------------------------------
module testbench import rrs_pkg::*; ();

	localparam int  LIMIT_CYCLES = 200000;
	localparam int  HOLD_CYCLES  = 300;
	localparam int  TAIL_CYCLES  = 20;
	localparam int  ITEM_TARGET  = 100;
	localparam logic [VALUE_W-1:0] MIN_VAL = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] MAX_VAL = 32'h7FFF_FFFF;

	// One request for the input channel, plus a flag that pauses the sender.
	typedef struct {
		value_t value;
		logic   last;
		bit     pause_after;
	} load_item_t;

	// One sorted result as the block should present it.
	typedef struct {
		value_t sorted_value;
		rank_t  rank;
		logic   already_sorted;
		logic   end_of_run;
	} sorted_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrs_in_if  din ();
	rrs_out_if dout ();

	rank_radix_sorter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	load_item_t     load_q[$];
	sorted_result_t due_sorted[$];
	value_t         set_vals[$];
	bit             set_in_order = 1'b1;
	sorted_result_t head;

	int  total_items;
	int  sent;
	int  sets_done;
	int  dropped;
	int  checked;
	int  errors;
	int  cycles;
	int  phase;
	int  send_idle;
	int  recv_idle;
	int  hold_left;
	bit  hold_used;
	bit  pausing;

	// Pause flag of the request currently on the channel.
	bit  load_q_head_pause;

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idling schedule follows how far the stimulus has come.
	always_comb begin
		if (sent < total_items / 3) begin
			phase = 0;
			send_idle = 17;
			recv_idle = 76;
		end else if (sent < (2 * total_items) / 3) begin
			phase = 1;
			send_idle = 76;
			recv_idle = 17;
		end else begin
			phase = 2;
			send_idle = 0;
			recv_idle = 0;
		end
	end

	// Store one accepted value, and on a last request rank the set and queue
	// its results in ascending order, equal values in arrival order.
	task automatic load_value(input value_t v, input logic is_last);
		sorted_result_t slot[MAX_ITEMS];
		int n;
		int smaller;
		int ties;
		int pos;
		if (set_vals.size() < MAX_ITEMS) begin
			if (set_vals.size() > 0 && v < set_vals[$])
				set_in_order = 1'b0;
			set_vals.push_back(v);
		end else begin
			dropped++;
		end
		if (is_last) begin
			n = set_vals.size();
			for (int i = 0; i < n; i++) begin
				smaller = 0;
				ties = 0;
				for (int j = 0; j < n; j++) begin
					if (set_vals[j] < set_vals[i])
						smaller++;
					else if (j < i && set_vals[j] == set_vals[i])
						ties++;
				end
				pos = smaller + ties;
				slot[pos].sorted_value   = set_vals[i];
				slot[pos].rank           = rank_t'(smaller);
				slot[pos].already_sorted = set_in_order;
				slot[pos].end_of_run     = (pos == n - 1);
			end
			for (int p = 0; p < n; p++)
				due_sorted.push_back(slot[p]);
			set_vals.delete();
			set_in_order = 1'b1;
			sets_done++;
		end
	endtask

	function automatic void queue_set(input value_t vals[$], input bit pause);
		load_item_t item;
		foreach (vals[i]) begin
			item.value       = vals[i];
			item.last        = (i == vals.size() - 1);
			item.pause_after = pause && item.last;
			load_q.push_back(item);
		end
	endfunction

	// Sender: offers queued requests, idles at random, and pauses after a
	// marked request until every pending result has come back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid <= 1'b0;
			din.value <= '0;
			din.last  <= 1'b0;
			pausing = 1'b0;
		end else begin
			if (din.valid && din.ready) begin
				load_value(din.value, din.last);
				sent++;
				if (load_q_head_pause)
					pausing = 1'b1;
			end
			if (pausing && due_sorted.size() == 0)
				pausing = 1'b0;
			if (!din.valid || din.ready) begin
				if (load_q.size() != 0 && !pausing &&
					$urandom_range(99) >= send_idle) begin
					head_pause_next();
				end else begin
					din.valid <= 1'b0;
				end
			end
		end
	end

	task automatic head_pause_next();
		load_item_t item;
		item = load_q.pop_front();
		din.valid <= 1'b1;
		din.value <= item.value;
		din.last  <= item.last;
		load_q_head_pause = item.pause_after;
	endtask

	// Long stall on the result side, started once as soon as the block emits
	// while the sender still has requests to offer, so the chain holds its set
	// and the input stalls behind it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (!hold_used && dout.valid && !pausing && load_q.size() != 0) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver ready, idling at random outside the long stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
		end
	end

	// Monitor: compare each accepted result with the oldest pending one.
	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			checked++;
			if (due_sorted.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got value %0d rank %0d",
					$time, dout.sorted_value, dout.rank);
			end else begin
				head = due_sorted.pop_front();
				if (dout.sorted_value !== head.sorted_value) begin
					errors++;
					$display("%0t: sorted_value expected %0d, got %0d",
						$time, head.sorted_value, dout.sorted_value);
				end
				if (dout.rank !== head.rank) begin
					errors++;
					$display("%0t: rank expected %0d, got %0d",
						$time, head.rank, dout.rank);
				end
				if (dout.already_sorted !== head.already_sorted) begin
					errors++;
					$display("%0t: already_sorted expected %0b, got %0b",
						$time, head.already_sorted, dout.already_sorted);
				end
				if (dout.end_of_run !== head.end_of_run) begin
					errors++;
					$display("%0t: end_of_run expected %0b, got %0b",
						$time, head.end_of_run, dout.end_of_run);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results pending", $time, due_sorted.size());
			$display("rank_radix_sorter regression: fail");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		value_t vals[$];
		int     queued_items;
		int     size;
		int     mode;
		bit     over_done;

		// Directed sets: single extremes, ordered and reversed extremes,
		// ties out of order and in order, alternating bit patterns.
		vals = '{value_t'(MIN_VAL)};
		queue_set(vals, 1'b0);
		vals = '{value_t'(MAX_VAL)};
		queue_set(vals, 1'b0);
		vals = '{value_t'(MIN_VAL), -1, 0, 1, value_t'(MAX_VAL)};
		queue_set(vals, 1'b0);
		vals = '{value_t'(MAX_VAL), 1, 0, -1, value_t'(MIN_VAL)};
		queue_set(vals, 1'b0);
		vals = '{5, -3, 5, -3, 5};
		queue_set(vals, 1'b0);
		vals = '{7, 7, 7};
		queue_set(vals, 1'b0);
		vals = '{value_t'(32'h5555_5555), value_t'(32'hAAAA_AAAA)};
		queue_set(vals, 1'b0);

		// Random sets, mostly small, with one set that overruns the capacity.
		queued_items = load_q.size();
		over_done = 1'b0;
		while (queued_items < ITEM_TARGET) begin
			if (!over_done && queued_items >= 30) begin
				// Ordered full store, then two smaller values that are dropped,
				// the second one carrying last. The sender then waits for the
				// results.
				vals.delete();
				for (int i = 0; i < MAX_ITEMS; i++)
					vals.push_back(value_t'($urandom()));
				vals.sort();
				vals.push_back(value_t'(MIN_VAL));
				vals.push_back(value_t'(MIN_VAL));
				queue_set(vals, 1'b1);
				queued_items += vals.size();
				over_done = 1'b1;
			end
			size = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
			mode = $urandom_range(4);
			vals.delete();
			for (int i = 0; i < size; i++) begin
				case (mode)
				1: begin
					vals.push_back(value_t'($urandom_range(8)) - 4);
				end
				4: begin
					case ($urandom_range(3))
					0: vals.push_back(value_t'(MIN_VAL));
					1: vals.push_back(value_t'(MAX_VAL));
					2: vals.push_back(0);
					default: vals.push_back(-1);
					endcase
				end
				default: begin
					vals.push_back(value_t'($urandom()));
				end
				endcase
			end
			if (mode == 2)
				vals.sort();
			else if (mode == 3)
				vals.rsort();
			queue_set(vals, 1'b0);
			queued_items += size;
		end
		total_items = load_q.size();

		// Hold reset, then release it away from the active edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent < total_items || due_sorted.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d values in %0d sets loaded, %0d dropped at capacity",
			sent, sets_done, dropped);
		$display("%0d sorted results checked, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("rank_radix_sorter regression: pass");
		end else begin
			$display("rank_radix_sorter regression: fail");
		end
		$finish;
	end

endmodule
